[rtl/flpte_pkg.sv]
// Shared types and constants of the four-level page table engine.
package flpte_pkg;

    localparam int FUNC_W            = 2;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int FLAG_W            = 12;
    localparam int STAT_W            = 2;
    localparam int OFFS_W            = 12;
    localparam int IDX_W             = 9;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LVL_W             = 2;

    localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_DIR  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_WRITE   = 1;
    localparam int BIT_USER    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_MAP   = 2'd0,
        FN_UNMAP = 2'd1,
        FN_TRANS = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_RESP
    } t_state;

endpackage

[rtl/flpte_ram.sv]
// Generic single-port RAM with registered read data.
module flpte_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/four_level_page_table_engine.sv]
// Top level of the four-level page table engine: walk sequencer and table store.
// A walk reads and checks each level in S_READ and S_CHECK on the single table memory
// port, then S_RESP registers the result; a new item is taken only in S_IDLE.
// A walk may stop early at level k (0 to 2) on an absent entry or an exhausted pool.
// After reset a clearing pass writes zero to all TABLE_PAGES*512 entries,
// one per cycle, with o_ready low; the pool pointer restarts at table page 1.
module four_level_page_table_engine #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [flpte_pkg::FUNC_W-1:0]  i_func,
    input  logic [flpte_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [flpte_pkg::PA_W-1:0]    i_phys_addr,
    input  logic [flpte_pkg::FLAG_W-1:0]  i_page_flags,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [flpte_pkg::PA_W-1:0]    o_phys_out,
    output logic [flpte_pkg::STAT_W-1:0]  o_status
);

    import flpte_pkg::*;

    localparam int PG_W  = $clog2(TABLE_PAGES);
    localparam int NF_W  = $clog2(TABLE_PAGES + 1);
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int AW    = PG_W + IDX_W;
    localparam int FR_W  = PA_W - OFFS_W;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [NF_W-1:0]     r_next_free, n_next_free;
    logic                r_out_valid, n_out_valid;

    t_func               r_func, n_func;
    logic [VA_W-1:0]     r_vaddr, n_vaddr;
    logic [FR_W-1:0]     r_frame, n_frame;
    logic [FLAG_W-1:0]   r_flags, n_flags;
    logic [LVL_W-1:0]    r_level, n_level;
    logic [PG_W-1:0]     r_page, n_page;
    logic [AW-1:0]       r_slot, n_slot;
    logic [PA_W-1:0]     r_res_phys, n_res_phys;
    t_status             r_res_status, n_res_status;
    logic [PA_W-1:0]     r_out_phys, n_out_phys;
    t_status             r_out_status, n_out_status;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [PA_W-1:0]     ram_wdata;
    logic [PA_W-1:0]     ram_rdata;
    logic [IDX_W-1:0]    w_idx;
    logic [PA_W-1:0]     w_table_entry;
    logic [PA_W-1:0]     w_leaf_entry;

    flpte_ram #(
        .WIDTH (PA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_level)
            LVL_TOP:  w_idx = r_vaddr[OFFS_W + 3*IDX_W +: IDX_W];
            LVL_DIR:  w_idx = r_vaddr[OFFS_W + 2*IDX_W +: IDX_W];
            LVL_MID:  w_idx = r_vaddr[OFFS_W + IDX_W +: IDX_W];
            LVL_LEAF: w_idx = r_vaddr[OFFS_W +: IDX_W];
        endcase
    end

    always_comb begin
        w_table_entry                    = '0;
        w_table_entry[OFFS_W +: PG_W]    = r_next_free[PG_W-1:0];
        w_table_entry[BIT_PRESENT]       = 1'b1;
        w_table_entry[BIT_WRITE]         = 1'b1;
        w_table_entry[BIT_USER]          = r_flags[BIT_USER];
    end

    assign w_leaf_entry = {r_frame, r_flags | (FLAG_W'(1) << BIT_PRESENT)};

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_next_free  = r_next_free;
        n_out_valid  = r_out_valid;
        n_func       = r_func;
        n_vaddr      = r_vaddr;
        n_frame      = r_frame;
        n_flags      = r_flags;
        n_level      = r_level;
        n_page       = r_page;
        n_slot       = r_slot;
        n_res_phys   = r_res_phys;
        n_res_status = r_res_status;
        n_out_phys   = r_out_phys;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_addr     = r_slot;
        ram_wdata    = '0;
        o_ready      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_func       = t_func'(i_func);
                    n_vaddr      = i_virt_addr;
                    n_frame      = i_phys_addr[PA_W-1:OFFS_W];
                    n_flags      = i_page_flags;
                    n_level      = LVL_TOP;
                    n_page       = '0;
                    n_res_phys   = '0;
                    n_res_status = ST_DONE;
                    n_state      = (t_func'(i_func) == FN_NONE) ? S_RESP : S_READ;
                end
            end
            S_READ: begin
                ram_addr = {r_page, w_idx};
                n_slot   = {r_page, w_idx};
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (r_level != LVL_LEAF) begin
                    if (ram_rdata[BIT_PRESENT]) begin
                        n_page  = ram_rdata[OFFS_W +: PG_W];
                        n_level = r_level + LVL_W'(1);
                        n_state = S_READ;
                    end else if (r_func == FN_MAP) begin
                        if (r_next_free >= NF_W'(TABLE_PAGES)) begin
                            n_res_status = ST_EXHAUSTED;
                            n_state      = S_RESP;
                        end else begin
                            ram_we      = 1'b1;
                            ram_wdata   = w_table_entry;
                            n_page      = r_next_free[PG_W-1:0];
                            n_next_free = r_next_free + NF_W'(1);
                            n_level     = r_level + LVL_W'(1);
                            n_state     = S_READ;
                        end
                    end else begin
                        n_res_status = ST_ABSENT;
                        n_state      = S_RESP;
                    end
                end else begin
                    priority if (r_func == FN_MAP) begin
                        ram_we    = 1'b1;
                        ram_wdata = w_leaf_entry;
                    end else if (r_func == FN_UNMAP) begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                    end else begin
                        n_res_phys = {ram_rdata[PA_W-1:OFFS_W], r_vaddr[OFFS_W-1:0]};
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_phys   = r_res_phys;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= NF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_vaddr      <= n_vaddr;
        r_frame      <= n_frame;
        r_flags      <= n_flags;
        r_level      <= n_level;
        r_page       <= n_page;
        r_slot       <= n_slot;
        r_res_phys   <= n_res_phys;
        r_res_status <= n_res_status;
        r_out_phys   <= n_out_phys;
        r_out_status <= n_out_status;
    end

    assign o_valid    = r_out_valid;
    assign o_phys_out = r_out_phys;
    assign o_status   = r_out_status;

    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free >= NF_W'(1) && r_next_free <= NF_W'(TABLE_PAGES))
        else $error("Table pool pointer out of range.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_phys_out == '0)
        else $error("Failed walk returned a nonzero address.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("Engine ready again right after taking an item.");

    a_alloc_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_next_free != $past(r_next_free) |-> $past(r_func == FN_MAP))
        else $error("Table allocated outside a map walk.");

endmodule
